/* src/uer_pkg.sv */
// Shared types, constants and register codes of the ultrasonic echo ranger.
// Used by the channel interfaces and by every module of the block.
package uer_pkg;

    localparam int COUNTER_BITS_DEF = 15;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 15;
    localparam int DIST_W      = 10;

    localparam int TICKS_PER_CM = 58;
    localparam logic [DIST_W-1:0] TIMEOUT_CM = 10'd999;

    localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER_LOW  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER_HIGH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_NEAR_LIMIT   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FAR_LIMIT    = 3'd4;

    localparam logic [7:0]        TRIGGER_LOW_RST  = 8'd3;
    localparam logic [7:0]        TRIGGER_HIGH_RST = 8'd12;
    localparam logic [14:0]       TIMEOUT_RST      = 15'd30000;
    localparam logic [DIST_W-1:0] NEAR_LIMIT_RST   = 10'd2;
    localparam logic [DIST_W-1:0] FAR_LIMIT_RST    = 10'd50;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_LOW  = 3'd1,
        PH_HIGH = 3'd2,
        PH_WAIT = 3'd3,
        PH_MEAS = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0]        trigger_low_ticks;
        logic [7:0]        trigger_high_ticks;
        logic [14:0]       timeout_ticks;
        logic [DIST_W-1:0] near_limit_cm;
        logic [DIST_W-1:0] far_limit_cm;
    } cfg_t;

    typedef struct packed {
        logic              trigger_level;
        logic              busy_res;
        logic              done_res;
        logic              timed_out;
        logic [DIST_W-1:0] distance_cm;
        logic              object_present;
        logic              presence_changed;
    } result_t;

endpackage

/* src/uer_channels.sv */
// Valid/ready channel interfaces of the echo ranger: tick requests, results
// and configuration writes. Depends on uer_pkg for field widths.
interface uer_tick_if;
    logic valid;
    logic ready;
    logic start_req;
    logic echo_level;

    modport source (output valid, output start_req, output echo_level, input ready);
    modport sink (input valid, input start_req, input echo_level, output ready);
endinterface

interface uer_result_if;
    logic                       valid;
    logic                       ready;
    logic                       trigger_level;
    logic                       busy_res;
    logic                       done_res;
    logic                       timed_out;
    logic [uer_pkg::DIST_W-1:0] distance_cm;
    logic                       object_present;
    logic                       presence_changed;

    modport source (
        output valid, output trigger_level, output busy_res, output done_res,
        output timed_out, output distance_cm, output object_present,
        output presence_changed, input ready
    );
    modport sink (
        input valid, input trigger_level, input busy_res, input done_res,
        input timed_out, input distance_cm, input object_present,
        input presence_changed, output ready
    );
endinterface

interface uer_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [uer_pkg::CFG_INDEX_W-1:0] index;
    logic [uer_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* src/uer_cfg_regs.sv */
// Configuration register file of the echo ranger with reset values.
// Depends on uer_pkg and the uer_cfg_if interface.
module uer_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    uer_cfg_if.sink       cfg,
    output uer_pkg::cfg_t regs
);

    uer_pkg::cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.trigger_low_ticks  <= uer_pkg::TRIGGER_LOW_RST;
            regs_reg.trigger_high_ticks <= uer_pkg::TRIGGER_HIGH_RST;
            regs_reg.timeout_ticks      <= uer_pkg::TIMEOUT_RST;
            regs_reg.near_limit_cm      <= uer_pkg::NEAR_LIMIT_RST;
            regs_reg.far_limit_cm       <= uer_pkg::FAR_LIMIT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                uer_pkg::REG_TRIGGER_LOW:  regs_reg.trigger_low_ticks  <= cfg.data[7:0];
                uer_pkg::REG_TRIGGER_HIGH: regs_reg.trigger_high_ticks <= cfg.data[7:0];
                uer_pkg::REG_TIMEOUT:      regs_reg.timeout_ticks      <= cfg.data[14:0];
                uer_pkg::REG_NEAR_LIMIT:   regs_reg.near_limit_cm      <= cfg.data[9:0];
                uer_pkg::REG_FAR_LIMIT:    regs_reg.far_limit_cm       <= cfg.data[9:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

/* src/uer_ranger_core.sv */
// Measurement sequencer of the echo ranger: phase state machine, tick counter,
// running divide-by-58 counter and presence tracking. Depends on uer_pkg.
module uer_ranger_core #(
    parameter int COUNTER_BITS = uer_pkg::COUNTER_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             start_req,
    input  logic             echo_level,
    input  uer_pkg::cfg_t    regs,
    output uer_pkg::result_t result
);

    localparam int CW = COUNTER_BITS;
    localparam int QW = COUNTER_BITS - 5;
    localparam int DW = (QW > uer_pkg::DIST_W) ? QW : uer_pkg::DIST_W;
    localparam int LW = (CW > 15) ? CW : 15;
    localparam logic [CW-1:0] CNT_ONE     = CW'(1);
    localparam logic [LW-1:0] CNT_MAX_EXT = LW'({CW{1'b1}});
    localparam logic [5:0]    REM_LAST    = 6'(uer_pkg::TICKS_PER_CM - 1);

    uer_pkg::phase_t phase_reg, phase_next;
    logic [CW-1:0]   tick_reg, tick_next;
    logic [QW-1:0]   quo_reg, quo_next;
    logic [5:0]      rem_reg, rem_next;
    logic            reported_reg;
    logic            last_pres_reg;

    logic [LW-1:0] timeout_ext;
    logic [LW-1:0] lim_wide;
    logic [CW-1:0] lim;
    logic [CW-1:0] tick_inc;
    logic [CW-1:0] low_ext;
    logic [CW-1:0] high_ext;
    logic          low_over;
    logic          high_over;
    logic          wait_tmo;
    logic          meas_tmo;
    logic          done;
    logic          tmo;
    logic [DW-1:0] dist_cm;
    logic          pres;
    logic          changed;

    assign timeout_ext = LW'(regs.timeout_ticks);

    always_comb
    begin
        if (timeout_ext == '0)
        begin
            lim_wide = LW'(1);
        end
        else if (timeout_ext > CNT_MAX_EXT)
        begin
            lim_wide = CNT_MAX_EXT;
        end
        else
        begin
            lim_wide = timeout_ext;
        end
    end

    assign lim       = lim_wide[CW-1:0];
    assign tick_inc  = tick_reg + CNT_ONE;
    assign low_ext   = CW'(regs.trigger_low_ticks);
    assign high_ext  = (regs.trigger_high_ticks == 8'd0) ? CNT_ONE
                                                         : CW'(regs.trigger_high_ticks);
    assign low_over  = tick_reg >= low_ext;
    assign high_over = tick_reg >= high_ext;
    assign wait_tmo  = echo_level ? (CNT_ONE >= lim) : (tick_inc >= lim);
    assign meas_tmo  = tick_inc >= lim;

    // Completion and timeout for this tick.
    always_comb
    begin
        done = 1'b0;
        tmo  = 1'b0;
        case (phase_reg)
            uer_pkg::PH_WAIT:
            begin
                done = wait_tmo;
                tmo  = wait_tmo;
            end
            uer_pkg::PH_MEAS:
            begin
                done = !echo_level || meas_tmo;
                tmo  = echo_level && meas_tmo;
            end
            default:
            begin
            end
        endcase
    end

    assign dist_cm = tmo ? DW'(uer_pkg::TIMEOUT_CM) : DW'(quo_reg);
    assign pres    = (dist_cm >= DW'(regs.near_limit_cm))
                     && (dist_cm <= DW'(regs.far_limit_cm));
    assign changed = !reported_reg || (last_pres_reg != pres);

    // Next phase, tick count and running quotient.
    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        case (phase_reg)
            uer_pkg::PH_LOW:
            begin
                if (low_over)
                begin
                    phase_next = uer_pkg::PH_HIGH;
                    tick_next  = CNT_ONE;
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            uer_pkg::PH_HIGH:
            begin
                if (high_over)
                begin
                    phase_next = uer_pkg::PH_WAIT;
                    tick_next  = '0;
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            uer_pkg::PH_WAIT:
            begin
                if (echo_level)
                begin
                    tick_next = CNT_ONE;
                    quo_next  = '0;
                    rem_next  = 6'd1;
                    if (!wait_tmo)
                    begin
                        phase_next = uer_pkg::PH_MEAS;
                    end
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            uer_pkg::PH_MEAS:
            begin
                if (echo_level)
                begin
                    tick_next = tick_inc;
                    if (rem_reg == REM_LAST)
                    begin
                        rem_next = '0;
                        quo_next = quo_reg + QW'(1);
                    end
                    else
                    begin
                        rem_next = rem_reg + 6'd1;
                    end
                end
            end
            default:
            begin
                phase_next = uer_pkg::PH_IDLE;
                if (start_req)
                begin
                    phase_next = (regs.trigger_low_ticks != 8'd0) ? uer_pkg::PH_LOW
                                                                  : uer_pkg::PH_HIGH;
                    tick_next  = CNT_ONE;
                end
            end
        endcase
        if (done)
        begin
            phase_next = uer_pkg::PH_IDLE;
            tick_next  = '0;
        end
    end

    // Result of this tick.
    always_comb
    begin
        result.trigger_level    = (phase_next == uer_pkg::PH_HIGH);
        result.busy_res         = (phase_next != uer_pkg::PH_IDLE);
        result.done_res         = done;
        result.timed_out        = tmo;
        result.distance_cm      = done ? dist_cm[uer_pkg::DIST_W-1:0] : '0;
        result.object_present   = done && pres;
        result.presence_changed = done && changed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= uer_pkg::PH_IDLE;
            tick_reg      <= '0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            reported_reg  <= 1'b0;
            last_pres_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            quo_reg   <= quo_next;
            rem_reg   <= rem_next;
            if (done)
            begin
                reported_reg  <= 1'b1;
                last_pres_reg <= pres;
            end
        end
    end

endmodule

/* src/ultrasonic_echo_ranger_unit.sv */
// Ultrasonic echo ranger top level: one request per microsecond tick, one result per
// request. The block takes one request every clock cycle while its results are taken,
// and returns each result through the input register and then the result register, with the
// phase sequencer and its running divide-by-58 counter between them. A result that waits
// to be taken holds the result register while one more request is buffered.
// Depends on uer_pkg, uer_channels, uer_cfg_regs and uer_ranger_core.
module ultrasonic_echo_ranger_unit #(
    parameter int COUNTER_BITS = uer_pkg::COUNTER_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    uer_cfg_if.sink       cfg,
    uer_tick_if.sink      tick,
    uer_result_if.source  result
);

    uer_pkg::cfg_t    regs;
    uer_pkg::result_t core_res;
    uer_pkg::result_t out_reg;

    logic in_valid_reg;
    logic start_reg;
    logic echo_reg;
    logic out_valid_reg;
    logic advance;

    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready = !in_valid_reg || advance;

    uer_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    uer_ranger_core #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .start_req  (start_reg),
        .echo_level (echo_reg),
        .regs       (regs),
        .result     (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (tick.ready)
            begin
                in_valid_reg <= tick.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            start_reg <= tick.start_req;
            echo_reg  <= tick.echo_level;
        end
        if (advance)
        begin
            out_reg <= core_res;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.trigger_level    = out_reg.trigger_level;
    assign result.busy_res         = out_reg.busy_res;
    assign result.done_res         = out_reg.done_res;
    assign result.timed_out        = out_reg.timed_out;
    assign result.distance_cm      = out_reg.distance_cm;
    assign result.object_present   = out_reg.object_present;
    assign result.presence_changed = out_reg.presence_changed;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.done_res |-> !out_reg.busy_res && !out_reg.trigger_level)
        else $error("Completed measurement still reports busy or trigger.");

    a_timeout_distance: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.timed_out |->
            out_reg.done_res && (out_reg.distance_cm == uer_pkg::TIMEOUT_CM))
        else $error("Timeout result without done or with wrong distance.");

    a_idle_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.done_res |->
            (out_reg.distance_cm == '0) && !out_reg.object_present
            && !out_reg.presence_changed)
        else $error("Measurement fields set on a tick without done.");

    a_advance_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("Advanced request did not produce a pending result.");

endmodule
